>>> hw/rtl/lbbt_pkg.sv
// ----------------------------------------------------------------------------
// Label bounding-box table package
// Shared constants, codes and word types for the bounding-box table.
// ----------------------------------------------------------------------------
package lbbt_pkg;

  localparam int MaxLabels = 255;
  localparam int CoordBits = 10;
  localparam int LabelBits = 8;
  localparam int SizeBits  = CoordBits + 1;
  localparam int AddrBits  = 3;
  localparam int DataBits  = 32;

  localparam logic [LabelBits-1:0] NumLabelsReset = LabelBits'(MaxLabels);

  // Register byte addresses, decoded on paddr bit 2.
  localparam logic RegNumLabels = 1'b0;

  typedef enum logic [1:0] {
    ModePixel = 2'd0,
    ModeRead  = 2'd1,
    ModeClear = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
    logic [LabelBits-1:0] label;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [CoordBits-1:0] box_x;
    logic [CoordBits-1:0] box_y;
    logic [SizeBits-1:0]  box_width;
    logic [SizeBits-1:0]  box_height;
  } out_t;

  typedef struct packed {
    logic [CoordBits-1:0] xmin;
    logic [CoordBits-1:0] xmax;
    logic [CoordBits-1:0] ymin;
    logic [CoordBits-1:0] ymax;
  } box_t;

endpackage

>>> hw/rtl/lbbt_box_ram.sv
// ----------------------------------------------------------------------------
// Box store RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lbbt_box_ram import lbbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [LabelBits-1:0] waddr_i,
  input  box_t                 wdata_i,
  input  logic                 re_i,
  input  logic [LabelBits-1:0] raddr_i,
  output box_t                 rdata_o
);

  box_t mem_q [MaxLabels];
  box_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read before write on a same-address collision; the caller forwards.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/label_bounding_box_table.sv
// ----------------------------------------------------------------------------
// Label bounding-box table
// Keeps min/max column and row per label; pixel words widen a box, read
// words return x, y, width and height, clear words forget every label.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_t: mode, row, col, label
//  out     | output    | out_valid_o / out_ready_i | out_t: found, box_x, box_y,
//          |           |                           |        box_width, box_height
//  cfg     | input     | APB psel/penable/pready   | num_labels at address 0
//
// Flow: one word per clock while no read word stalls. A word passes through
//   the box RAM read and then the update stage; a forward register covers a
//   word that hits the entry the word ahead of it is writing back.
// Reset: seen flags sit in flip-flops and clear at once, so no clearing pass
//   is needed; box entries are only used while their seen flag is set.
// Stalls: only a read word waits, when the output register is still full;
//   pixel and clear words never stall.
// ----------------------------------------------------------------------------
module label_bounding_box_table import lbbt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_i,
  // Result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_o,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [LabelBits-1:0] num_labels_q, num_labels_d;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegNumLabels);

  always_comb begin
    num_labels_d = num_labels_q;
    if (cfg_wr) begin
      num_labels_d = pwdata[LabelBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegNumLabels) begin
      prdata = DataBits'(num_labels_q);
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: issue the RAM read for the incoming word
  // --------------------------------------------------------------------------
  logic                  accept;
  logic                  s1_valid_q, s1_valid_d;
  in_t                   s1_item_q;
  logic                  s1_done;
  logic                  s1_in_use;
  logic [LabelBits-1:0]  s1_slot;
  logic [LabelBits-1:0]  in_slot;
  logic                  s1_wr_en;
  box_t                  s1_wr_data;
  box_t                  rd_data;
  box_t                  entry;
  logic                  fwd_hit_q, fwd_hit_d;
  box_t                  fwd_data_q;
  logic [MaxLabels-1:0]  seen_q, seen_d;
  logic                  s1_seen;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  assign in_ready_o = !s1_valid_q || s1_done;
  assign accept     = in_valid_i && in_ready_o;
  assign in_slot    = in_i.label - LabelBits'(1);

  lbbt_box_ram u_box_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr_en),
    .waddr_i (s1_slot),
    .wdata_i (s1_wr_data),
    .re_i    (accept && (in_i.label != '0)),
    .raddr_i (in_slot),
    .rdata_o (rd_data)
  );

  // Capture a write-back to the slot being read at the same edge; the RAM
  // returns the old entry in that case.
  assign fwd_hit_d = accept ? (s1_wr_en && (s1_slot == in_slot)) : fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_i;
      fwd_data_q <= s1_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage: read-modify-write of the box, result formation
  // --------------------------------------------------------------------------
  assign s1_slot   = s1_item_q.label - LabelBits'(1);
  assign s1_in_use = (s1_item_q.label != '0) && (s1_item_q.label <= num_labels_q)
                     && (s1_item_q.label <= LabelBits'(MaxLabels));
  assign s1_seen   = s1_in_use && seen_q[s1_slot];
  assign entry     = fwd_hit_q ? fwd_data_q : rd_data;

  // Hold a read word while the output register is full and not drained.
  assign s1_done = s1_valid_q &&
                   ((s1_item_q.mode != ModeRead) || !out_valid_q || out_ready_i);

  assign s1_wr_en = s1_done && (s1_item_q.mode == ModePixel) && s1_in_use;

  always_comb begin
    if (!s1_seen) begin
      s1_wr_data.xmin = s1_item_q.col;
      s1_wr_data.xmax = s1_item_q.col;
      s1_wr_data.ymin = s1_item_q.row;
      s1_wr_data.ymax = s1_item_q.row;
    end else begin
      s1_wr_data.xmin = (s1_item_q.col < entry.xmin) ? s1_item_q.col : entry.xmin;
      s1_wr_data.xmax = (s1_item_q.col > entry.xmax) ? s1_item_q.col : entry.xmax;
      s1_wr_data.ymin = (s1_item_q.row < entry.ymin) ? s1_item_q.row : entry.ymin;
      s1_wr_data.ymax = (s1_item_q.row > entry.ymax) ? s1_item_q.row : entry.ymax;
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (s1_done) begin
      unique case (s1_item_q.mode)
        ModePixel: begin
          if (s1_in_use) begin
            seen_d[s1_slot] = 1'b1;
          end
        end
        ModeClear: seen_d = '0;
        default:   seen_d = seen_q;
      endcase
    end
  end

  // Output register: advance on a finished read word, drop on take.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (s1_done && (s1_item_q.mode == ModeRead)) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (s1_seen) begin
        out_d.found      = 1'b1;
        out_d.box_x      = entry.xmin;
        out_d.box_y      = entry.ymin;
        out_d.box_width  = {1'b0, entry.xmax} - {1'b0, entry.xmin} + SizeBits'(1);
        out_d.box_height = {1'b0, entry.ymax} - {1'b0, entry.ymin} + SizeBits'(1);
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_labels_q <= NumLabelsReset;
      s1_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      seen_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      num_labels_q <= num_labels_d;
      s1_valid_q   <= s1_valid_d;
      fwd_hit_q    <= fwd_hit_d;
      seen_q       <= seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_done && (s1_item_q.mode == ModeRead) |=> out_valid_q)
    else $error("read word left update stage without a result");

  a_clear_forgets_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_done && (s1_item_q.mode == ModeClear) |=> (seen_q == '0))
    else $error("seen flags not cleared after clear word");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |->
      (out_q.box_x == '0) && (out_q.box_y == '0) &&
      (out_q.box_width == '0) && (out_q.box_height == '0))
    else $error("unseen label returned nonzero box");

  a_hit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.found |-> (out_q.box_width != '0) && (out_q.box_height != '0))
    else $error("seen label returned empty box");

  a_stall_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_done |-> (s1_item_q.mode == ModeRead) && out_valid_q)
    else $error("update stage stalled without a full output register");

endmodule

>>> test/label_bounding_box_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding-box table checker
// Watches the word, result and register ports, keeps its own box table and
// compares every result word against the box it predicts.
// ----------------------------------------------------------------------------
module label_bounding_box_table_checker import lbbt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  in_t                 in_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  out_t                out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  boxes_due_o
);

  logic [LabelBits-1:0] labels_in_use;
  bit                   seen_tbl [1:MaxLabels];
  box_t                 box_tbl  [1:MaxLabels];
  out_t                 boxes_due_q [$];

  initial begin
    fail_count_o = 0;
    boxes_due_o  = 0;
  end

  // Apply one accepted word to the table; queue the box a read must return.
  task automatic track_word(input in_t w);
    out_t want;
    box_t b;
    bit   live;
    live = (w.label != '0) && (w.label <= labels_in_use) && (int'(w.label) <= MaxLabels);
    want = '0;
    case (w.mode)
      ModePixel: begin
        if (live) begin
          b = box_tbl[w.label];
          if (!seen_tbl[w.label]) begin
            b.xmin = w.col;
            b.xmax = w.col;
            b.ymin = w.row;
            b.ymax = w.row;
          end else begin
            if (w.col < b.xmin) b.xmin = w.col;
            if (w.col > b.xmax) b.xmax = w.col;
            if (w.row < b.ymin) b.ymin = w.row;
            if (w.row > b.ymax) b.ymax = w.row;
          end
          box_tbl[w.label]  = b;
          seen_tbl[w.label] = 1'b1;
        end
      end
      ModeRead: begin
        if (live && seen_tbl[w.label]) begin
          b               = box_tbl[w.label];
          want.found      = 1'b1;
          want.box_x      = b.xmin;
          want.box_y      = b.ymin;
          want.box_width  = SizeBits'({1'b0, b.xmax} - {1'b0, b.xmin}) + SizeBits'(1);
          want.box_height = SizeBits'({1'b0, b.ymax} - {1'b0, b.ymin}) + SizeBits'(1);
        end
        boxes_due_q = {boxes_due_q, want};
      end
      ModeClear: begin
        foreach (seen_tbl[i]) seen_tbl[i] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_box(input out_t got);
    out_t want;
    if (boxes_due_q.size() == 0) begin
      fail_count_o++;
      $display("%0t: box word with none expected: found %0d x %0d y %0d w %0d h %0d",
               $time, got.found, got.box_x, got.box_y, got.box_width, got.box_height);
    end else begin
      want = boxes_due_q.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (got.found !== want.found)
          $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
        if (got.box_x !== want.box_x)
          $display("%0t: box_x expected %0d, got %0d", $time, want.box_x, got.box_x);
        if (got.box_y !== want.box_y)
          $display("%0t: box_y expected %0d, got %0d", $time, want.box_y, got.box_y);
        if (got.box_width !== want.box_width)
          $display("%0t: box_width expected %0d, got %0d", $time, want.box_width,
                   got.box_width);
        if (got.box_height !== want.box_height)
          $display("%0t: box_height expected %0d, got %0d", $time, want.box_height,
                   got.box_height);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      labels_in_use = NumLabelsReset;
      foreach (seen_tbl[i]) seen_tbl[i] = 1'b0;
      boxes_due_q.delete();
      boxes_due_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {RegNumLabels, 2'b00}) begin
        labels_in_use = pwdata[LabelBits-1:0];
      end
      if (in_valid_i && in_ready_o) track_word(in_i);
      if (out_valid_o && out_ready_i) check_box(out_o);
      boxes_due_o = boxes_due_q.size();
    end
  end

endmodule

>>> test/tb_label_bounding_box_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding-box table testbench
// Drives pixel, read and clear words through the table under several label
// counts and flow-control patterns; a checker beside the block predicts and
// compares every result word, and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_label_bounding_box_table;
  import lbbt_pkg::*;

  // Mode code the block does not define; it must leave the table untouched.
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int CoordMax     = (1 << CoordBits) - 1;
  // Long receiver hold-off used to back the pipeline up into the input.
  localparam int HoldCycles   = 200;
  // Pixel words give no result, so allow the two-stage pipe to drain.
  localparam int SettleCycles = 6;
  // Cycles without any accepted word, taken result or register access before the run is declared hung.
  localparam int QuietLimit   = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;

  int                   fail_count;
  int                   boxes_due;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  bit                   hold_req;
  int                   quiet_cycles;
  // Mirror of the label count last written, used to steer label choice.
  logic [LabelBits-1:0] labels_in_use;

  label_bounding_box_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  label_bounding_box_table_checker box_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .boxes_due_o  (boxes_due)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Receiver: stall at the current rate, or hold off for a long stretch when
  // asked so the output register stays full and read words back up.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: reset the count on reset, any accepted word, taken result or register access.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Favor a few labels in use so boxes grow; also hit the count boundary,
  // labels out of use and the background label.
  function automatic logic [LabelBits-1:0] pick_label();
    int sel;
    int top;
    sel = $urandom_range(99);
    top = (labels_in_use < 12) ? int'(labels_in_use) : 12;
    if (labels_in_use != '0 && sel < 75) return LabelBits'($urandom_range(1, top));
    if (sel < 85) return labels_in_use + LabelBits'($urandom_range(1));
    if (sel < 95) return LabelBits'($urandom_range(255));
    return '0;
  endfunction

  // Pick a blob center; some land on the edges of the frame.
  function automatic int pick_center();
    if ($urandom_range(99) < 15) return $urandom_range(1) ? CoordMax : 0;
    return $urandom_range(CoordMax);
  endfunction

  // Scatter a pixel around a center, clamped to the frame.
  function automatic int near_coord(input int c);
    int v;
    v = c + int'($urandom_range(32)) - 16;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return v;
  endfunction

  // Offer one word after a random gap; hold it until accepted.
  task automatic send_fields(input logic [1:0] mode, input int row, input int col,
                             input int lab);
    in_t w;
    w.mode  = mode_e'(mode);
    w.row   = CoordBits'(row);
    w.col   = CoordBits'(col);
    w.label = LabelBits'(lab);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every expected box, then let the pipe drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (boxes_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_num_labels(input logic [LabelBits-1:0] count);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegNumLabels, 2'b00};
    pwdata  <= DataBits'(count);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    labels_in_use = count;
  endtask

  // One phase: set the label count and flow control, then send blobs of
  // pixels followed by a read of their label, mixed with clears, unused
  // modes and noise. Every word sent advances the tally.
  task automatic run_phase(input logic [LabelBits-1:0] count, input int idle_pct,
                           input int stall_pct, input int target, input bit squeeze);
    int                   tally;
    int                   roll;
    int                   cx;
    int                   cy;
    logic [LabelBits-1:0] lab;
    mode_e                m;
    write_num_labels(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_req       = squeeze;
    tally          = 0;
    while (tally < target) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        lab = pick_label();
        cx  = pick_center();
        cy  = pick_center();
        repeat ($urandom_range(1, 8)) begin
          send_fields(ModePixel, near_coord(cy), near_coord(cx), lab);
          tally++;
        end
        send_fields(ModeRead, $urandom_range(CoordMax), $urandom_range(CoordMax), lab);
        tally++;
      end else if (roll < 78) begin
        send_fields(ModeClear, $urandom_range(CoordMax), $urandom_range(CoordMax),
                    $urandom_range(255));
        tally++;
      end else if (roll < 81) begin
        send_fields(ModeUnused, $urandom_range(CoordMax), $urandom_range(CoordMax),
                    pick_label());
        tally++;
      end else begin
        m   = $urandom_range(1) ? ModeRead : ModePixel;
        lab = LabelBits'($urandom_range(255));
        send_fields(m, $urandom_range(CoordMax), $urandom_range(CoordMax), lab);
        tally++;
      end
    end
    settle();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    labels_in_use  = NumLabelsReset;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset label count: unseen and background
    // reads, full-frame and single-point boxes, the top label, an unused
    // mode, a clear and a rebuild after it.
    send_fields(ModeRead,  0, 0, 5);
    send_fields(ModeRead,  CoordMax, CoordMax, 0);
    send_fields(ModePixel, 0, 0, 1);
    send_fields(ModePixel, CoordMax, CoordMax, 1);
    send_fields(ModeRead,  0, 0, 1);
    send_fields(ModePixel, CoordMax, 0, 255);
    send_fields(ModePixel, 512, 700, 255);
    send_fields(ModeRead,  0, 0, 255);
    send_fields(ModePixel, 5, 5, 0);
    send_fields(ModeRead,  0, 0, 0);
    send_fields(ModePixel, 341, 682, 2);
    send_fields(ModeRead,  0, 0, 2);
    send_fields(ModeUnused, 0, 0, 2);
    send_fields(ModeRead,  0, 0, 2);
    send_fields(ModeClear, 0, 0, 0);
    send_fields(ModeRead,  0, 0, 1);
    send_fields(ModeRead,  0, 0, 255);
    send_fields(ModePixel, 682, 341, 1);
    send_fields(ModeRead,  0, 0, 1);
    send_fields(ModePixel, CoordMax, CoordMax, 128);
    send_fields(ModePixel, 0, 0, 128);
    send_fields(ModeRead,  0, 0, 128);
    settle();

    // Shrink the label count: a seen label above it must read as not found.
    write_num_labels(8'd3);
    send_fields(ModeRead,  0, 0, 1);
    send_fields(ModeRead,  0, 0, 128);
    send_fields(ModePixel, 100, 100, 4);
    send_fields(ModeRead,  0, 0, 4);
    settle();

    // Random phases; the first also holds the receiver off for a long stretch.
    run_phase(8'd255, 0, 0, 150, 1'b1);
    run_phase(8'd1, 79, 0, 110, 1'b0);
    run_phase(8'd0, 0, 79, 30, 1'b0);
    run_phase(LabelBits'($urandom_range(2, 254)), 0, 79, 150, 1'b0);
    run_phase(LabelBits'($urandom_range(2, 254)), 32, 32, 200, 1'b0);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
